[rtl/clsr_pkg.sv]
`timescale 1ns / 1ps

package clsr_pkg;

   // Field widths
   localparam int GEN_W  = 31;
   localparam int CNT_W  = 32;
   localparam int MUL_W  = 16;
   localparam int PROD_W = GEN_W + MUL_W;
   localparam int FOLD_W = 32;
   localparam int CORR_W = 8;
   localparam int REQ_W  = 32;
   localparam int RSP_W  = 64;

   // Generator constants; 2^31 = modulus + correction
   localparam logic [MUL_W-1:0]  MUL_ONE  = 16'd40014;
   localparam logic [MUL_W-1:0]  MUL_TWO  = 16'd40692;
   localparam logic [FOLD_W-1:0] MOD_ONE  = 32'd2147483563;
   localparam logic [FOLD_W-1:0] MOD_TWO  = 32'd2147483399;
   localparam logic [CORR_W-1:0] CORR_ONE = 8'd85;
   localparam logic [CORR_W-1:0] CORR_TWO = 8'd249;
   localparam logic [GEN_W-1:0]  IMM1     = 31'd2147483562;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WARM_MUL,
      ST_WARM_FOLD,
      ST_WARM_WB,
      ST_DRAW_MUL,
      ST_DRAW_FOLD,
      ST_DRAW_WB,
      ST_DRAW_READ,
      ST_DRAW_OUT
   } state_type;

   typedef struct packed {
      logic load;     // capture an accepted word, bump the call counter
      logic reseed;   // load both generators from the seed
      logic mul;      // multiply stage of both generators and slot estimate
      logic fold;     // fold stage of both generators and slot bound
      logic wb_fill;  // write back generator one during warm-up, fill table
      logic wb_draw;  // write back both generators, settle the slot
      logic rd;       // read the shuffle table at the slot
      logic finish;   // form the result, store generator one, load output
   } cmd_type;

   typedef struct packed {
      logic warm_last;
   } status_type;

endpackage

[rtl/clsr_ctrl.sv]
`timescale 1ns / 1ps

module clsr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_reseed,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output clsr_pkg::cmd_type      cmd,
   input  clsr_pkg::status_type   status
);
   import clsr_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_tready   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load   = 1'b1;
               cmd.reseed = req_reseed;
               state_in   = req_reseed ? ST_WARM_MUL : ST_DRAW_MUL;
            end
         end
         ST_WARM_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_WARM_FOLD;
         end
         ST_WARM_FOLD: begin
            cmd.fold = 1'b1;
            state_in = ST_WARM_WB;
         end
         ST_WARM_WB: begin
            cmd.wb_fill = 1'b1;
            state_in    = status.warm_last ? ST_DRAW_MUL : ST_WARM_MUL;
         end
         ST_DRAW_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DRAW_FOLD;
         end
         ST_DRAW_FOLD: begin
            cmd.fold = 1'b1;
            state_in = ST_DRAW_WB;
         end
         ST_DRAW_WB: begin
            cmd.wb_draw = 1'b1;
            state_in    = ST_DRAW_READ;
         end
         ST_DRAW_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_DRAW_OUT;
         end
         ST_DRAW_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

[rtl/clsr_datapath.sv]
`timescale 1ns / 1ps

module clsr_datapath #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  clsr_pkg::cmd_type             cmd,
   output clsr_pkg::status_type          status,
   input  logic [clsr_pkg::GEN_W-1:0]    seed_value,
   output logic [clsr_pkg::GEN_W-1:0]    random_value,
   output logic [clsr_pkg::CNT_W-1:0]    draw_count
);
   import clsr_pkg::*;

   localparam int IDX_W   = $clog2(TABLE_DEPTH);
   localparam int EST_W   = IDX_W + 1;
   localparam int WARM_W  = $clog2(TABLE_DEPTH + 8);
   localparam int BOUND_W = 32;
   localparam int DIFF_W  = GEN_W + 2;
   localparam longint unsigned SLOT_DIV_L = 64'd1 + 64'(IMM1) / 64'(TABLE_DEPTH);
   localparam longint unsigned RECIP_L    = (64'd1 << GEN_W) / SLOT_DIV_L;
   localparam int RECIP_W = $clog2(RECIP_L + 1);
   localparam int RP_W    = GEN_W + RECIP_W;
   localparam logic [GEN_W-1:0]   SLOT_DIV   = GEN_W'(SLOT_DIV_L);
   localparam logic [RECIP_W-1:0] RECIP      = RECIP_W'(RECIP_L);
   localparam logic [WARM_W-1:0]  WARM_LAST  = WARM_W'(TABLE_DEPTH + 7);
   localparam logic [WARM_W-1:0]  WARM_DEPTH = WARM_W'(TABLE_DEPTH);
   localparam logic [EST_W-1:0]   EST_DEPTH  = EST_W'(TABLE_DEPTH);
   localparam logic [IDX_W-1:0]   IDX_LAST   = IDX_W'(TABLE_DEPTH - 1);

   // Architectural state
   logic [GEN_W-1:0]  gen1_ff, gen1_in;
   logic [GEN_W-1:0]  gen2_ff, gen2_in;
   logic [GEN_W-1:0]  last_ff, last_in;
   logic [CNT_W-1:0]  count_ff;
   logic [WARM_W-1:0] warm_cnt_ff;
   logic [TABLE_DEPTH-1:0] valid_ff;
   logic [GEN_W-1:0]  shuffle_mem [TABLE_DEPTH];

   // Generator pipeline
   logic [PROD_W-1:0] prod1_ff, prod2_ff;
   logic [FOLD_W-1:0] fold1_ff, fold2_ff;
   logic [FOLD_W-1:0] fold1_c, fold2_c;
   logic [GEN_W-1:0]  red1, red2;

   // Slot pipeline
   logic [RP_W-1:0]    rprod_ff;
   logic [EST_W-1:0]   est_ff, est_c, est_inc;
   logic [BOUND_W-1:0] bound_ff, bound_c;
   logic [EST_W-1:0]   slot_sum;
   logic [IDX_W-1:0]   slot_ff, slot_in;

   // Table access and result
   logic [GEN_W-1:0]  rd_data_ff;
   logic              rd_valid_ff;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [GEN_W-1:0]  wr_data;
   logic              fill_hit;
   logic [GEN_W-1:0]  entry;
   logic [DIFF_W-1:0] diff;
   logic [GEN_W-1:0]  result;
   logic [GEN_W-1:0]  seed_eff;
   logic [GEN_W-1:0]  rsp_value_ff;
   logic [CNT_W-1:0]  rsp_count_ff;

   assign seed_eff = (seed_value == '0) ? GEN_W'(1) : seed_value;

   // Fold the high part back in: 2^31 is congruent to the correction term
   assign fold1_c = FOLD_W'(prod1_ff[PROD_W-1:GEN_W]) * FOLD_W'(CORR_ONE)
                  + FOLD_W'(prod1_ff[GEN_W-1:0]);
   assign fold2_c = FOLD_W'(prod2_ff[PROD_W-1:GEN_W]) * FOLD_W'(CORR_TWO)
                  + FOLD_W'(prod2_ff[GEN_W-1:0]);
   assign red1 = (fold1_ff >= MOD_ONE) ? GEN_W'(fold1_ff - MOD_ONE) : GEN_W'(fold1_ff);
   assign red2 = (fold2_ff >= MOD_TWO) ? GEN_W'(fold2_ff - MOD_TWO) : GEN_W'(fold2_ff);

   // Slot estimate is the true quotient or one below it
   assign est_c    = EST_W'(rprod_ff >> GEN_W);
   assign est_inc  = est_c + EST_W'(1);
   assign bound_c  = BOUND_W'(est_inc) * BOUND_W'(SLOT_DIV);
   assign slot_sum = est_ff + EST_W'({1'b0, last_ff} >= bound_ff);
   assign slot_in  = (slot_sum >= EST_DEPTH) ? IDX_LAST : slot_sum[IDX_W-1:0];

   assign fill_hit = cmd.wb_fill && (warm_cnt_ff < WARM_DEPTH);
   assign wr_en    = fill_hit || cmd.finish;
   assign wr_addr  = cmd.finish ? slot_ff : warm_cnt_ff[IDX_W-1:0];
   assign wr_data  = cmd.finish ? gen1_ff : red1;

   // Unwritten slots read as zero
   assign entry  = rd_valid_ff ? rd_data_ff : '0;
   assign diff   = {2'b00, entry} - {2'b00, gen2_ff};
   assign result = (diff[DIFF_W-1] || diff == '0) ? GEN_W'(diff + DIFF_W'(IMM1))
                                                   : GEN_W'(diff);

   always_comb begin
      gen1_in = gen1_ff;
      gen2_in = gen2_ff;
      last_in = last_ff;
      if (cmd.load && cmd.reseed) begin
         gen1_in = seed_eff;
         gen2_in = seed_eff;
      end else if (cmd.wb_fill) begin
         gen1_in = red1;
         if (warm_cnt_ff == '0) begin
            last_in = red1;
         end
      end else if (cmd.wb_draw) begin
         gen1_in = red1;
         gen2_in = red2;
      end else if (cmd.finish) begin
         last_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen1_ff     <= GEN_W'(1);
         gen2_ff     <= GEN_W'(1);
         last_ff     <= '0;
         count_ff    <= '0;
         warm_cnt_ff <= '0;
         valid_ff    <= '0;
      end else begin
         gen1_ff <= gen1_in;
         gen2_ff <= gen2_in;
         last_ff <= last_in;
         if (cmd.load) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (cmd.load && cmd.reseed) begin
            warm_cnt_ff <= WARM_LAST;
         end else if (cmd.wb_fill && warm_cnt_ff != '0) begin
            warm_cnt_ff <= warm_cnt_ff - WARM_W'(1);
         end
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod1_ff <= PROD_W'(gen1_ff) * PROD_W'(MUL_ONE);
         prod2_ff <= PROD_W'(gen2_ff) * PROD_W'(MUL_TWO);
         rprod_ff <= RP_W'(last_ff) * RP_W'(RECIP);
      end
      if (cmd.fold) begin
         fold1_ff <= fold1_c;
         fold2_ff <= fold2_c;
         est_ff   <= est_c;
         bound_ff <= bound_c;
      end
      if (cmd.wb_draw) begin
         slot_ff <= slot_in;
      end
      if (cmd.rd) begin
         rd_data_ff  <= shuffle_mem[slot_ff];
         rd_valid_ff <= valid_ff[slot_ff];
      end
      if (wr_en) begin
         shuffle_mem[wr_addr] <= wr_data;
      end
      if (cmd.finish) begin
         rsp_value_ff <= result;
         rsp_count_ff <= count_ff;
      end
   end

   assign status.warm_last = (warm_cnt_ff == '0);
   assign random_value     = rsp_value_ff;
   assign draw_count       = rsp_count_ff;

endmodule

[rtl/combined_lcg_shuffle_rng_unit.sv]
`timescale 1ns / 1ps
// Channel | Direction | Handshake            | Payload
// req     | in        | req_tvalid/tready    | tuser: reseed flag; tdata: seed
// rsp     | out       | rsp_tvalid/tready    | tdata: random value, call count
//
// A draw runs through an accept state, then multiply, fold and write-back of
// both generators, a registered table read and the combine step, which waits
// while the output register is still full. A reseed adds warm-up steps of
// generator one before the draw, each a multiply, fold and reduce pass.
// Synchronous active-high reset; the table reads as zero until written.
// One word is in flight at a time; a finished word waits in the output
// register while the next request is accepted.

module combined_lcg_shuffle_rng_unit #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [clsr_pkg::REQ_W-1:0]  req_tdata,  // [30:0] seed_value, [31] zero
   input  logic                        req_tuser,  // [0] action
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [clsr_pkg::RSP_W-1:0]  rsp_tdata   // [30:0] random_value,
                                                   // [62:31] draw_count, [63] zero
);
   import clsr_pkg::*;

   cmd_type          cmd;
   status_type       status;
   logic [GEN_W-1:0] random_value;
   logic [CNT_W-1:0] draw_count;

   clsr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_reseed (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   clsr_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .seed_value   (req_tdata[GEN_W-1:0]),
      .random_value (random_value),
      .draw_count   (draw_count)
   );

   assign rsp_tdata = {1'b0, draw_count, random_value};

endmodule

[rtl/clsr_checker.sv]
`timescale 1ns / 1ps

module clsr_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tvalid,
   input logic                        req_tready,
   input logic [clsr_pkg::REQ_W-1:0]  req_tdata,
   input logic                        req_tuser,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [clsr_pkg::RSP_W-1:0]  rsp_tdata
);
   import clsr_pkg::*;

   logic [CNT_W-1:0] last_count_ff;
   logic             seen_ff;
   logic             rsp_fire;

   assign rsp_fire = rsp_tvalid && rsp_tready;

   // track the count of the last delivered word
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else if (rsp_fire) begin
         seen_ff       <= 1'b1;
         last_count_ff <= rsp_tdata[GEN_W +: CNT_W];
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   a_value_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[GEN_W-1:0] != '0 && rsp_tdata[GEN_W-1:0] <= IMM1
                     && rsp_tdata[RSP_W-1] == 1'b0)
      else $error("random value out of range");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && seen_ff |-> rsp_tdata[GEN_W +: CNT_W] == last_count_ff + CNT_W'(1))
      else $error("call count skipped or repeated");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready && !$rose(rsp_tvalid))
      else $error("request taken while a word is in progress");

endmodule

bind combined_lcg_shuffle_rng_unit clsr_checker u_checker (.*);
